>>> src/nas_pkg.sv
`default_nettype none

package nas_pkg;

    localparam int IDX_W       = 6;
    localparam int ANGLE_W     = 16;
    localparam int DIST_W      = 17;
    localparam int MASK_BITS   = 48;
    localparam int MASK_IW     = 6;
    localparam int MAX_RESULTS = 47;

    localparam logic [DIST_W-1:0] HALF_TURN = 17'h08000;
    localparam logic [DIST_W-1:0] FULL_TURN = 17'h10000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic [ANGLE_W-1:0] az;
    } t_cand;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_best;

endpackage

`default_nettype wire

>>> src/nas_req_if.sv
`default_nettype none

interface nas_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        polarization;
    logic [5:0]  antenna;
    logic [15:0] angle;
    logic [5:0]  want_count;
    logic [47:0] excluded_mask;

    modport source (
        output valid, func, polarization, antenna, angle, want_count, excluded_mask,
        input  ready
    );
    modport sink (
        input  valid, func, polarization, antenna, angle, want_count, excluded_mask,
        output ready
    );
endinterface

`default_nettype wire

>>> src/nas_res_if.sv
`default_nettype none

interface nas_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] chosen_antenna;
    logic       valid_res;
    logic       last;
    logic [5:0] rank;

    modport source (
        output valid, chosen_antenna, valid_res, last, rank,
        input  ready
    );
    modport sink (
        input  valid, chosen_antenna, valid_res, last, rank,
        output ready
    );
endinterface

`default_nettype wire

>>> src/nas_az_mem.sv
`default_nettype none

module nas_az_mem #(
    parameter int DEPTH = 96,
    parameter int AW    = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [15:0]        o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/nas_near_unit.sv
`default_nettype none

module nas_near_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic [nas_pkg::ANGLE_W-1:0]   i_angle,
    input  wire nas_pkg::t_cand                i_cand,
    output nas_pkg::t_best                     o_best
);

    logic                         r_found;
    logic [nas_pkg::IDX_W-1:0]    r_best_idx;
    logic [nas_pkg::DIST_W-1:0]   r_best_d;
    logic [nas_pkg::ANGLE_W-1:0]  diff;
    logic [nas_pkg::DIST_W-1:0]   cur_d;
    logic                         take;

    always_comb begin
        diff = i_angle - i_cand.az;
        if ({1'b0, diff} > nas_pkg::HALF_TURN) begin
            cur_d = nas_pkg::FULL_TURN - {1'b0, diff};
        end else begin
            cur_d = {1'b0, diff};
        end
        take = i_cand.vld && (!r_found || (cur_d < r_best_d));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx <= i_cand.idx;
            r_best_d   <= cur_d;
        end
    end

    assign o_best.found = r_found;
    assign o_best.idx   = r_best_idx;

endmodule

`default_nettype wire

>>> src/nearest_angle_selector_core.sv
`default_nettype none

// Write item: written to the azimuth table on transfer; input ready stays high after it.
// Query: a counting pass over all antennas to count allowed ones, a setup state, then
// per result a table scan (one table read per cycle), a drain state, then select and emit.
// Nothing qualifies: a single result (valid_res low, last high) after the counting pass and setup.
// Input ready only when no query is running; one result register on the output.
// Synchronous active-low reset clears control state; the azimuth table is not cleared.
module nearest_angle_selector_core #(
    parameter int NUM_ANTENNAS = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nas_req_if.sink   i_req,
    nas_res_if.source o_res
);

    localparam int IW    = $clog2(NUM_ANTENNAS);
    localparam int AW    = $clog2(2 * NUM_ANTENNAS);
    localparam int CW    = $clog2(NUM_ANTENNAS + 1);
    localparam int DEPTH = 2 * NUM_ANTENNAS;

    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ANTENNAS - 1);

    nas_pkg::t_state r_state, n_state;

    logic [IW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_avail, n_avail;
    logic [5:0]                    r_want;
    logic [5:0]                    r_total, n_total;
    logic [5:0]                    r_rank, n_rank;
    logic                          r_empty, n_empty;
    logic                          r_pol;
    logic [15:0]                   r_angle;
    logic [47:0]                   r_mask;
    logic [NUM_ANTENNAS-1:0]       r_taken;
    logic                          r_rd_vld;
    logic [IW-1:0]                 r_rd_idx;

    logic                          r_out_vld;
    logic [5:0]                    r_out_ant;
    logic                          r_out_valid_res;
    logic                          r_out_last;
    logic [5:0]                    r_out_rank;

    logic                          req_xfer;
    logic                          query_start;
    logic                          out_free;
    logic                          emit_go;
    logic                          clear_best;
    logic                          count_excl;
    logic                          rd_excl;
    logic                          is_last;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [15:0]                   mem_rdata;
    logic [IW-1:0]                 best_iw;
    nas_pkg::t_cand                cand;
    nas_pkg::t_best                best;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign query_start = req_xfer && (i_req.func == nas_pkg::FUNC_QUERY);
    assign out_free    = !r_out_vld || o_res.ready;
    assign best_iw     = best.idx[IW-1:0];
    assign is_last     = ((r_rank + 6'd1) == r_total);

    assign count_excl = (32'(r_idx) < nas_pkg::MASK_BITS)
                        && r_mask[nas_pkg::MASK_IW'(r_idx)];
    assign rd_excl    = (32'(r_rd_idx) < nas_pkg::MASK_BITS)
                        && r_mask[nas_pkg::MASK_IW'(r_rd_idx)];

    assign mem_we    = req_xfer && (i_req.func == nas_pkg::FUNC_WRITE)
                       && ({1'b0, i_req.antenna} < 7'(NUM_ANTENNAS));
    assign mem_waddr = i_req.polarization
                       ? (AW'(NUM_ANTENNAS) + AW'(i_req.antenna[IW-1:0]))
                       : AW'(i_req.antenna[IW-1:0]);
    assign mem_raddr = r_pol ? (AW'(NUM_ANTENNAS) + AW'(r_idx)) : AW'(r_idx);

    nas_az_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_req.angle),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        cand.vld = r_rd_vld && !rd_excl && !r_taken[r_rd_idx];
        cand.idx = nas_pkg::IDX_W'(r_rd_idx);
        cand.az  = mem_rdata;
    end

    nas_near_unit u_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (clear_best),
        .i_angle (r_angle),
        .i_cand  (cand),
        .o_best  (best)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_avail     = r_avail;
        n_total     = r_total;
        n_rank      = r_rank;
        n_empty     = r_empty;
        emit_go     = 1'b0;
        clear_best  = 1'b0;
        i_req.ready = 1'b0;
        case (r_state)
            nas_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (query_start) begin
                    n_idx   = '0;
                    n_avail = '0;
                    n_rank  = '0;
                    n_state = nas_pkg::S_COUNT;
                end
            end
            nas_pkg::S_COUNT: begin
                if (!count_excl) begin
                    n_avail = r_avail + CW'(1);
                end
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = nas_pkg::S_SETUP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            nas_pkg::S_SETUP: begin
                clear_best = 1'b1;
                if ({1'b0, r_want} <= 7'(r_avail)) begin
                    n_total = r_want;
                end else begin
                    n_total = 6'(r_avail);
                end
                n_empty = (n_total == 6'd0);
                n_state = n_empty ? nas_pkg::S_EMIT : nas_pkg::S_SCAN;
            end
            nas_pkg::S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = nas_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            nas_pkg::S_DRAIN: begin
                n_state = nas_pkg::S_EMIT;
            end
            nas_pkg::S_EMIT: begin
                if (out_free) begin
                    emit_go = 1'b1;
                    if (r_empty || is_last) begin
                        n_state = nas_pkg::S_IDLE;
                    end else begin
                        clear_best = 1'b1;
                        n_rank     = r_rank + 6'd1;
                        n_idx      = '0;
                        n_state    = nas_pkg::S_SCAN;
                    end
                end
            end
            default: begin
                n_state = nas_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nas_pkg::S_IDLE;
            r_idx     <= '0;
            r_avail   <= '0;
            r_total   <= '0;
            r_rank    <= '0;
            r_empty   <= 1'b0;
            r_taken   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_avail  <= n_avail;
            r_total  <= n_total;
            r_rank   <= n_rank;
            r_empty  <= n_empty;
            r_rd_vld <= (r_state == nas_pkg::S_SCAN);
            if (query_start) begin
                r_taken <= '0;
            end else if (emit_go && !r_empty) begin
                r_taken[best_iw] <= 1'b1;
            end
            if (emit_go) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (query_start) begin
            r_pol   <= i_req.polarization;
            r_angle <= i_req.angle;
            r_mask  <= i_req.excluded_mask;
            r_want  <= (i_req.want_count > 6'(nas_pkg::MAX_RESULTS))
                       ? 6'(nas_pkg::MAX_RESULTS) : i_req.want_count;
        end
        if (emit_go) begin
            r_out_ant       <= r_empty ? 6'd0 : best.idx;
            r_out_valid_res <= !r_empty;
            r_out_last      <= r_empty || is_last;
            r_out_rank      <= r_empty ? 6'd0 : r_rank;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.chosen_antenna = r_out_ant;
    assign o_res.valid_res      = r_out_valid_res;
    assign o_res.last           = r_out_last;
    assign o_res.rank           = r_out_rank;

    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nas_pkg::S_EMIT && !r_empty) |-> best.found)
        else $error("no candidate found for a pending rank");

    a_emit_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nas_pkg::S_EMIT && !r_empty) |-> !r_taken[best_iw])
        else $error("selected antenna already reported");

    a_taken_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && !r_empty) |=> ($countones(r_taken) == $past($countones(r_taken)) + 1))
        else $error("taken set did not grow by one");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nas_pkg::S_EMIT && !r_empty) |-> (r_rank < r_total))
        else $error("rank beyond result count");

endmodule

`default_nettype wire

>>> sim/nearest_angle_selector_core_tb.sv
`timescale 1ns / 1ps

module nearest_angle_selector_core_tb;

    localparam int NUM_ANTENNAS = 48;
    localparam int RANDOM_ITEMS = 400;
    localparam int N_DIRECTED   = 22;

    localparam logic FUNC_WRITE = nas_pkg::FUNC_WRITE;
    localparam logic FUNC_QUERY = nas_pkg::FUNC_QUERY;

    typedef struct packed {
        logic        func;
        logic        polarization;
        logic [5:0]  antenna;
        logic [15:0] angle;
        logic [5:0]  want_count;
        logic [47:0] excluded_mask;
    } t_req;

    typedef struct packed {
        logic [5:0] chosen_antenna;
        logic       valid_res;
        logic       last;
        logic [5:0] rank;
    } t_sel;

    typedef struct {
        logic        func;
        logic        polarization;
        logic [5:0]  antenna;
        logic [15:0] angle;
        logic [5:0]  want_count;
        logic [47:0] excluded_mask;
        bit          typed;
        t_sel        outcome;
    } t_step;

    localparam t_sel NO_PICK           = '0;
    localparam t_sel NOTHING_QUALIFIES = '{6'd0, 1'b0, 1'b1, 6'd0};
    localparam t_sel ONLY_ANT0         = '{6'd0, 1'b1, 1'b1, 6'd0};
    localparam t_sel ONLY_ANT47        = '{6'd47, 1'b1, 1'b1, 6'd0};

    t_step directed_steps [N_DIRECTED] = '{
        '{FUNC_WRITE, 1'b0, 6'd0,  16'h0000, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_WRITE, 1'b0, 6'd47, 16'hFFFF, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_WRITE, 1'b1, 6'd1,  16'h8000, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_WRITE, 1'b1, 6'd2,  16'h8000, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_WRITE, 1'b1, 6'd47, 16'h0000, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_WRITE, 1'b0, 6'd63, 16'h1234, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_WRITE, 1'b1, 6'd48, 16'hFFFF, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_WRITE, 1'b0, 6'd5,  16'h8001, 6'd0,  48'h0,             1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'h0000, 6'd0,  48'h0,             1'b1, NOTHING_QUALIFIES},
        '{FUNC_QUERY, 1'b1, 6'd0,  16'h0064, 6'd5,  48'hFFFF_FFFF_FFFF, 1'b1, NOTHING_QUALIFIES},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'h0000, 6'd1,  48'h0,             1'b1, ONLY_ANT0},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'hFFFF, 6'd1,  48'h7FFF_FFFF_FFFF, 1'b1, ONLY_ANT47},
        '{FUNC_QUERY, 1'b1, 6'd0,  16'h0000, 6'd1,  48'h7FFF_FFFF_FFFF, 1'b1, ONLY_ANT47},
        '{FUNC_QUERY, 1'b1, 6'd0,  16'h0000, 6'd63, 48'h0,             1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'h8000, 6'd47, 48'h0,             1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b1, 6'd0,  16'h8000, 6'd48, 48'h5555_5555_5555, 1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'h4000, 6'd3,  48'hAAAA_AAAA_AAAA, 1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'h1234, 6'd32, 48'h7FFF_FFFF_FFFE, 1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b1, 6'd0,  16'h8000, 6'd2,  48'h0000_0000_0001, 1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'h0001, 6'd4,  48'h0,             1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b1, 6'd0,  16'hFFFF, 6'd16, 48'hFFFF_0000_0000, 1'b0, NO_PICK},
        '{FUNC_QUERY, 1'b0, 6'd0,  16'h7FFF, 6'd10, 48'h0000_FFFF_FFFF, 1'b0, NO_PICK}
    };

    logic i_clk;
    logic i_rst_n;

    nas_req_if req_ch ();
    nas_res_if res_ch ();

    nearest_angle_selector_core #(
        .NUM_ANTENNAS(NUM_ANTENNAS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    logic [15:0] az_mirror [2][NUM_ANTENNAS];
    t_sel        selections_due [$];
    int          mismatches;
    int          items_sent;
    int          queries_sent;
    int          selections_checked;
    int          burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d selections outstanding", selections_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    // Rank allowed antennas by circular distance, lowest index wins a tie.
    task automatic rank_nearest(input t_req r);
        t_sel        picks [nas_pkg::MAX_RESULTS];
        logic [47:0] taken;
        logic [15:0] diff;
        logic [16:0] d;
        logic [16:0] best_d;
        int          limit;
        int          n;
        int          best;
        bit          found;
        taken  = '0;
        limit  = (r.want_count > nas_pkg::MAX_RESULTS) ? nas_pkg::MAX_RESULTS
                                                       : int'(r.want_count);
        n      = 0;
        found  = 1'b1;
        best   = 0;
        best_d = '0;
        while (n < limit && found) begin
            found = 1'b0;
            for (int i = 0; i < NUM_ANTENNAS; i++) begin
                if (!r.excluded_mask[i] && !taken[i]) begin
                    diff = r.angle - az_mirror[r.polarization][i];
                    d    = ({1'b0, diff} > nas_pkg::HALF_TURN)
                           ? nas_pkg::FULL_TURN - {1'b0, diff}
                           : {1'b0, diff};
                    if (!found || d < best_d) begin
                        best   = i;
                        best_d = d;
                        found  = 1'b1;
                    end
                end
            end
            if (found) begin
                taken[best] = 1'b1;
                picks[n]    = '{6'(best), 1'b1, 1'b0, 6'(n)};
                n++;
            end
        end
        if (n == 0) begin
            selections_due.push_back(NOTHING_QUALIFIES);
        end else begin
            for (int k = 0; k < n; k++) begin
                selections_due.push_back('{picks[k].chosen_antenna, 1'b1, k == n - 1,
                                           picks[k].rank});
            end
        end
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input t_req r, input bit typed, input t_sel typed_sel);
        pace();
        req_ch.valid         <= 1'b1;
        req_ch.func          <= r.func;
        req_ch.polarization  <= r.polarization;
        req_ch.antenna       <= r.antenna;
        req_ch.angle         <= r.angle;
        req_ch.want_count    <= r.want_count;
        req_ch.excluded_mask <= r.excluded_mask;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        if (r.func == FUNC_WRITE) begin
            if (r.antenna < NUM_ANTENNAS)
                az_mirror[r.polarization][r.antenna] = r.angle;
        end else begin
            queries_sent++;
            if (typed)
                selections_due.push_back(typed_sel);
            else
                rank_nearest(r);
        end
    endtask

    task automatic await_drain();
        do @(posedge i_clk); while (selections_due.size() != 0);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sel e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (selections_due.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got antenna %0d rank %0d",
                         $time, res_ch.chosen_antenna, res_ch.rank);
                mismatches++;
            end else begin
                e = selections_due.pop_front();
                check_field("chosen_antenna", e.chosen_antenna, res_ch.chosen_antenna);
                check_field("valid_res", e.valid_res, res_ch.valid_res);
                check_field("last", e.last, res_ch.last);
                check_field("rank", e.rank, res_ch.rank);
                selections_checked++;
            end
        end
    end

    initial begin
        int unsigned stall_mode;
        int unsigned rx_cycle;
        stall_mode   = 0;
        rx_cycle     = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom_range(0, 1));
                2:       res_ch.ready <= (rx_cycle % 4 == 0);
                default: res_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin
        t_req r;
        int   p;
        int   a;
        mismatches         = 0;
        items_sent         = 0;
        queries_sent       = 0;
        selections_checked = 0;
        burst_left         = 0;
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.func          <= FUNC_WRITE;
        req_ch.polarization  <= 1'b0;
        req_ch.antenna       <= '0;
        req_ch.angle         <= '0;
        req_ch.want_count    <= '0;
        req_ch.excluded_mask <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill both tables so no query reads an unwritten entry
        for (p = 0; p < 2; p++) begin
            for (a = 0; a < NUM_ANTENNAS; a++) begin
                r = '{FUNC_WRITE, 1'(p), 6'(a), 16'($urandom), 6'd0, 48'h0};
                send_item(r, 1'b0, NO_PICK);
            end
        end

        foreach (directed_steps[i]) begin
            r = '{directed_steps[i].func, directed_steps[i].polarization,
                  directed_steps[i].antenna, directed_steps[i].angle,
                  directed_steps[i].want_count, directed_steps[i].excluded_mask};
            send_item(r, directed_steps[i].typed, directed_steps[i].outcome);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                req_ch.valid <= 1'b0;
                await_drain();
            end
            p = $urandom_range(0, 1);
            a = $urandom_range(0, NUM_ANTENNAS - 1);
            r.polarization = 1'(p);
            r.antenna      = 6'($urandom_range(0, 63));
            r.want_count   = '0;
            r.excluded_mask = '0;
            if ($urandom_range(0, 9) < 7) begin
                r.func = FUNC_WRITE;
                if ($urandom_range(0, 15) != 0)
                    r.antenna = 6'($urandom_range(0, NUM_ANTENNAS - 1));
                case ($urandom_range(0, 7))
                    5: begin
                        case ($urandom_range(0, 3))
                            0:       r.angle = 16'h0000;
                            1:       r.angle = 16'hFFFF;
                            2:       r.angle = 16'h8000;
                            default: r.angle = 16'h4000;
                        endcase
                    end
                    6, 7:    r.angle = az_mirror[$urandom_range(0, 1)][a];
                    default: r.angle = 16'($urandom);
                endcase
            end else begin
                r.func = FUNC_QUERY;
                case ($urandom_range(0, 3))
                    2:       r.angle = az_mirror[p][a];
                    3:       r.angle = az_mirror[p][a] + 16'h8000;
                    default: r.angle = 16'($urandom);
                endcase
                case ($urandom_range(0, 19))
                    0:       r.want_count = 6'd0;
                    1, 2:    r.want_count = 6'($urandom_range(48, 63));
                    3, 4, 5: r.want_count = 6'($urandom_range(7, 47));
                    default: r.want_count = 6'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 9))
                    0, 1:    r.excluded_mask = 48'h0;
                    2:       r.excluded_mask = 48'hFFFF_FFFF_FFFF;
                    3:       r.excluded_mask = ~(rand48() & rand48() & rand48());
                    4, 5:    r.excluded_mask = rand48() | rand48();
                    default: r.excluded_mask = rand48() & rand48() & rand48();
                endcase
            end
            send_item(r, 1'b0, NO_PICK);
        end

        req_ch.valid <= 1'b0;
        await_drain();
        repeat (3 * NUM_ANTENNAS) @(posedge i_clk);

        $display("Ran %0d transfers (%0d queries on both polarizations), %0d results compared",
                 items_sent, queries_sent, selections_checked);
        $display("Counts from 0 to 63, masks from empty to full, ties and half-turn distances");
        if (mismatches == 0 && selections_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
src/nas_pkg.sv
src/nas_req_if.sv
src/nas_res_if.sv
src/nas_az_mem.sv
src/nas_near_unit.sv
src/nearest_angle_selector_core.sv
sim/nearest_angle_selector_core_tb.sv
